[rtl/tks_pkg.sv]
// Package for the top-K score selector: widths, store entry and memory
// request types, and the sequencer state encoding. No dependencies.
package tks_pkg;

  localparam int MAX_TOP_K = 16;
  localparam int IDX_W     = (MAX_TOP_K > 1) ? $clog2(MAX_TOP_K) : 1;
  localparam int CNT_W     = $clog2(MAX_TOP_K + 1);
  localparam int ID_W      = 32;
  localparam int SCORE_W   = 32;
  localparam int K_W       = 5;
  localparam int RANK_W    = 4;
  localparam int KC_W      = (CNT_W > K_W) ? CNT_W : K_W;

  localparam logic [K_W-1:0] K_RESET = K_W'(10);

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
  } tks_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    tks_entry_t       wdata;
    logic [IDX_W-1:0] raddr;
  } tks_mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CMP,
    S_COUNT,
    S_EMIT_RD,
    S_EMIT_LOAD,
    S_EMIT_WAIT
  } tks_state_t;

endpackage

[rtl/top_k_score_selector.sv]
// Top level of the top-K score selector: sequencer, shared rank comparator
// and sorted store. Depends on tks_pkg, tks_ctrl, tks_rank_cmp, tks_store.
//
// The block takes one word at a time, a (doc id, score) candidate, and keeps
// the best MAX_TOP_K candidates in a sorted store ordered by higher score
// first and, between equal scores, lower doc id first. Insertion walks the
// store from its bottom entry upward with one shared comparator: each cycle
// compares the candidate against one kept entry and shifts that entry down a
// slot while the candidate ranks ahead of it; in_stall stays high while the
// candidate is ranked. When the word carries last_candidate, the block then
// returns min(k_in_use, kept entries) hits, best first, with their rank and
// a mark on the final hit, and empties the store. Readout first sizes the
// set and then reads each hit through the store's single read port, and a
// hit is held while out_stall is high. A k_in_use of zero returns nothing,
// and values above the store depth return the whole store. The k_in_use
// register resets to 10, is always ready, and is meant to be written only
// while the block is idle.
module top_k_score_selector (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tks_pkg::ID_W-1:0]     in_doc_id,
  input  logic [tks_pkg::SCORE_W-1:0]  in_score,
  input  logic                         in_last_candidate,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tks_pkg::ID_W-1:0]     out_hit_doc_id,
  output logic [tks_pkg::SCORE_W-1:0]  out_hit_score,
  output logic [tks_pkg::RANK_W-1:0]   out_hit_rank,
  output logic                         out_last_hit,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tks_pkg::K_W-1:0]      cfg_k_in_use
);

  tks_pkg::tks_entry_t   cand;
  tks_pkg::tks_entry_t   rd_data;
  tks_pkg::tks_mem_req_t mem_req;
  logic                  ahead;

  // The comparator always sees the held candidate against the entry just
  // read from the store.
  tks_rank_cmp u_cmp (
    .cand  (cand),
    .kept  (rd_data),
    .ahead (ahead)
  );

  tks_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  tks_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_doc_id         (in_doc_id),
    .in_score          (in_score),
    .in_last_candidate (in_last_candidate),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit_doc_id    (out_hit_doc_id),
    .out_hit_score     (out_hit_score),
    .out_hit_rank      (out_hit_rank),
    .out_last_hit      (out_last_hit),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_k_in_use      (cfg_k_in_use),
    .cand              (cand),
    .ahead             (ahead),
    .mem_req           (mem_req),
    .rd_data           (rd_data)
  );

endmodule

[rtl/tks_store.sv]
// Sorted hit store: one write port and one registered read port.
// Depends on tks_pkg.
module tks_store (
  input  logic                 clk,
  input  tks_pkg::tks_mem_req_t req,
  output tks_pkg::tks_entry_t   rd_data
);

  tks_pkg::tks_entry_t mem [tks_pkg::MAX_TOP_K];
  tks_pkg::tks_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/tks_rank_cmp.sv]
// Shared ranking comparator: higher score first, lower id first on a tie.
// Depends on tks_pkg.
module tks_rank_cmp (
  input  tks_pkg::tks_entry_t cand,
  input  tks_pkg::tks_entry_t kept,
  output logic                ahead
);

  always_comb begin
    if (cand.score != kept.score) begin
      ahead = cand.score > kept.score;
    end else begin
      ahead = cand.id < kept.id;
    end
  end

endmodule

[rtl/tks_ctrl.sv]
// Sequencer of the top-K selector: insertion by walking the store from the
// bottom, then readout of the best hits. Depends on tks_pkg.
module tks_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tks_pkg::ID_W-1:0]      in_doc_id,
  input  logic [tks_pkg::SCORE_W-1:0]   in_score,
  input  logic                          in_last_candidate,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tks_pkg::ID_W-1:0]      out_hit_doc_id,
  output logic [tks_pkg::SCORE_W-1:0]   out_hit_score,
  output logic [tks_pkg::RANK_W-1:0]    out_hit_rank,
  output logic                          out_last_hit,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tks_pkg::K_W-1:0]       cfg_k_in_use,
  output tks_pkg::tks_entry_t           cand,
  input  logic                          ahead,
  output tks_pkg::tks_mem_req_t         mem_req,
  input  tks_pkg::tks_entry_t           rd_data
);

  tks_pkg::tks_state_t state_r, state_nxt;
  logic [tks_pkg::K_W-1:0]    k_r;
  logic [tks_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [tks_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [tks_pkg::CNT_W-1:0]  n_r, n_nxt;
  logic [tks_pkg::CNT_W-1:0]  emit_r, emit_nxt;
  tks_pkg::tks_entry_t        cand_r, cand_nxt;
  logic                       last_r, last_nxt;
  logic                       out_valid_r, out_valid_nxt;
  tks_pkg::tks_entry_t        out_ent_r, out_ent_nxt;
  logic [tks_pkg::RANK_W-1:0] out_rank_r, out_rank_nxt;
  logic                       out_last_r, out_last_nxt;

  logic [tks_pkg::CNT_W-1:0] idx_m1, idx_m2, count_inc, emit_inc, n_calc;
  logic [tks_pkg::KC_W-1:0]  keff;
  logic                      idx_in_store;

  assign idx_m1       = idx_r - tks_pkg::CNT_W'(1);
  assign idx_m2       = idx_r - tks_pkg::CNT_W'(2);
  assign emit_inc     = emit_r + tks_pkg::CNT_W'(1);
  assign idx_in_store = idx_r < tks_pkg::CNT_W'(tks_pkg::MAX_TOP_K);
  assign count_inc    = (count_r < tks_pkg::CNT_W'(tks_pkg::MAX_TOP_K)) ?
                        count_r + tks_pkg::CNT_W'(1) : count_r;

  // Effective k: values beyond the store depth ask for the whole store.
  always_comb begin
    if (tks_pkg::KC_W'(k_r) > tks_pkg::KC_W'(tks_pkg::MAX_TOP_K)) begin
      keff = tks_pkg::KC_W'(tks_pkg::MAX_TOP_K);
    end else begin
      keff = tks_pkg::KC_W'(k_r);
    end
    if (keff < tks_pkg::KC_W'(count_r)) begin
      n_calc = tks_pkg::CNT_W'(keff);
    end else begin
      n_calc = count_r;
    end
  end

  assign cand = cand_r;

  // Next state and datapath registers.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    emit_nxt      = emit_r;
    cand_nxt      = cand_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_ent_nxt   = out_ent_r;
    out_rank_nxt  = out_rank_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      tks_pkg::S_IDLE: begin
        if (in_valid) begin
          cand_nxt.id    = in_doc_id;
          cand_nxt.score = in_score;
          last_nxt       = in_last_candidate;
          idx_nxt        = count_r;
          state_nxt      = tks_pkg::S_FETCH;
        end
      end
      tks_pkg::S_FETCH: begin
        if (idx_r == '0) begin
          count_nxt = count_inc;
          state_nxt = last_r ? tks_pkg::S_COUNT : tks_pkg::S_IDLE;
        end else begin
          state_nxt = tks_pkg::S_CMP;
        end
      end
      tks_pkg::S_CMP: begin
        if (ahead) begin
          idx_nxt   = idx_m1;
          state_nxt = (idx_m1 == '0) ? tks_pkg::S_FETCH : tks_pkg::S_CMP;
        end else begin
          count_nxt = count_inc;
          state_nxt = last_r ? tks_pkg::S_COUNT : tks_pkg::S_IDLE;
        end
      end
      tks_pkg::S_COUNT: begin
        n_nxt    = n_calc;
        emit_nxt = '0;
        if (n_calc == '0) begin
          count_nxt = '0;
          state_nxt = tks_pkg::S_IDLE;
        end else begin
          state_nxt = tks_pkg::S_EMIT_RD;
        end
      end
      tks_pkg::S_EMIT_RD: begin
        state_nxt = tks_pkg::S_EMIT_LOAD;
      end
      tks_pkg::S_EMIT_LOAD: begin
        out_ent_nxt   = rd_data;
        out_rank_nxt  = tks_pkg::RANK_W'(emit_r);
        out_last_nxt  = emit_inc == n_r;
        out_valid_nxt = 1'b1;
        state_nxt     = tks_pkg::S_EMIT_WAIT;
      end
      tks_pkg::S_EMIT_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          emit_nxt      = emit_inc;
          if (out_last_r) begin
            count_nxt = '0;
            state_nxt = tks_pkg::S_IDLE;
          end else begin
            state_nxt = tks_pkg::S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = tks_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs: handshakes and store access.
  always_comb begin
    in_stall      = state_r != tks_pkg::S_IDLE;
    cfg_ready     = 1'b1;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx_r[tks_pkg::IDX_W-1:0];
    mem_req.wdata = cand_r;
    mem_req.raddr = idx_m1[tks_pkg::IDX_W-1:0];
    case (state_r)
      tks_pkg::S_FETCH: begin
        mem_req.we = idx_r == '0;
      end
      tks_pkg::S_CMP: begin
        if (ahead) begin
          mem_req.we    = idx_in_store;
          mem_req.wdata = rd_data;
          mem_req.raddr = idx_m2[tks_pkg::IDX_W-1:0];
        end else begin
          mem_req.we = idx_in_store;
        end
      end
      tks_pkg::S_EMIT_RD: begin
        mem_req.raddr = emit_r[tks_pkg::IDX_W-1:0];
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tks_pkg::S_IDLE;
      k_r         <= tks_pkg::K_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        k_r <= cfg_k_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    emit_r     <= emit_nxt;
    cand_r     <= cand_nxt;
    last_r     <= last_nxt;
    out_ent_r  <= out_ent_nxt;
    out_rank_r <= out_rank_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hit_doc_id = out_ent_r.id;
  assign out_hit_score  = out_ent_r.score;
  assign out_hit_rank   = out_rank_r;
  assign out_last_hit   = out_last_r;

endmodule

[rtl/tks_checker.sv]
// Port-level checks for the top-K score selector, bound to its top level.
// Depends on tks_pkg and top_k_score_selector.
module tks_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_last_candidate,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tks_pkg::ID_W-1:0]     out_hit_doc_id,
  input logic [tks_pkg::SCORE_W-1:0]  out_hit_score,
  input logic [tks_pkg::RANK_W-1:0]   out_hit_rank,
  input logic                         out_last_hit
);

  // A stalled hit holds its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit_doc_id) &&
      $stable(out_hit_score) && $stable(out_hit_rank) && $stable(out_last_hit))
    else $error("stalled hit word changed");

  // No candidate is taken while hits are being returned.
  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during readout");

  // A candidate that does not close a set produces no hit.
  a_no_early_hit: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last_candidate |=> !out_valid)
    else $error("hit without a last candidate");

  // Hits of one set come with consecutive ranks.
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_hit |-> ##3
      (out_valid && out_hit_rank == $past(out_hit_rank, 3) + 1'b1))
    else $error("hit rank did not advance by one");

  // Once the final hit is taken, the block takes candidates again.
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_hit |=> !in_stall)
    else $error("block not ready after last hit");

endmodule

bind top_k_score_selector tks_checker u_tks_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_last_candidate (in_last_candidate),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_hit_doc_id    (out_hit_doc_id),
  .out_hit_score     (out_hit_score),
  .out_hit_rank      (out_hit_rank),
  .out_last_hit      (out_last_hit)
);

[test/tb_top_k_score_selector.sv]
// Self-checking testbench for top_k_score_selector: directed and random candidate
// sets under random idling and output hold-off, checked against a built-in ranking
// model. Depends on tks_pkg and the top_k_score_selector RTL.
module tb_top_k_score_selector;

  // The run is stopped by the watchdog well past the slowest correct run.
  localparam int CYCLE_LIMIT   = 200000;
  // Long enough for any candidate still being ranked when the last expected
  // hit has been seen.
  localparam int SETTLE_CYCLES = 3 * (tks_pkg::MAX_TOP_K + 4);
  localparam int IDLE_PERCENT  = 35;
  localparam logic [tks_pkg::K_W-1:0] K_ZERO = '0;
  localparam logic [tks_pkg::K_W-1:0] K_ONE  = tks_pkg::K_W'(1);
  localparam logic [tks_pkg::K_W-1:0] K_FULL = tks_pkg::K_W'(tks_pkg::MAX_TOP_K);
  localparam logic [tks_pkg::K_W-1:0] K_OVER = tks_pkg::K_W'(tks_pkg::MAX_TOP_K + 1);
  localparam logic [tks_pkg::K_W-1:0] K_TOP  = '1;

  // One ranked hit as the block should return it.
  typedef struct {
    logic [tks_pkg::ID_W-1:0]    doc_id;
    logic [tks_pkg::SCORE_W-1:0] score;
    logic [tks_pkg::RANK_W-1:0]  rank;
    logic                        is_last;
  } hit_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [tks_pkg::ID_W-1:0]    in_doc_id;
  logic [tks_pkg::SCORE_W-1:0] in_score;
  logic                        in_last_candidate;
  logic                        out_valid;
  logic                        out_stall;
  logic [tks_pkg::ID_W-1:0]    out_hit_doc_id;
  logic [tks_pkg::SCORE_W-1:0] out_hit_score;
  logic [tks_pkg::RANK_W-1:0]  out_hit_rank;
  logic                        out_last_hit;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [tks_pkg::K_W-1:0]     cfg_k_in_use;

  // Ranking model: its own sorted store, fill level and k setting.
  logic [tks_pkg::ID_W-1:0]    ranked_ids[tks_pkg::MAX_TOP_K];
  logic [tks_pkg::SCORE_W-1:0] ranked_scores[tks_pkg::MAX_TOP_K];
  int                          ranked_fill;
  logic [tks_pkg::K_W-1:0]     k_setting;
  hit_t                        pending_hits[$];

  // Knobs shared between the stimulus and the stall process.
  bit in_gaps_on;
  bit out_gaps_on;
  int hold_request;
  int hold_left;

  int errors;
  int cycle_count;
  int candidates_sent;
  int sets_closed;
  int hits_checked;
  int k_writes;

  top_k_score_selector u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_doc_id         (in_doc_id),
    .in_score          (in_score),
    .in_last_candidate (in_last_candidate),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit_doc_id    (out_hit_doc_id),
    .out_hit_score     (out_hit_score),
    .out_hit_rank      (out_hit_rank),
    .out_last_hit      (out_last_hit),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_k_in_use      (cfg_k_in_use)
  );

  always #5 clk = ~clk;

  // True when candidate a belongs strictly ahead of candidate b: higher score
  // first, and the lower doc id first between equal scores.
  function automatic bit ranks_ahead(logic [tks_pkg::SCORE_W-1:0] a_score,
                                     logic [tks_pkg::ID_W-1:0]    a_id,
                                     logic [tks_pkg::SCORE_W-1:0] b_score,
                                     logic [tks_pkg::ID_W-1:0]    b_id);
    if (a_score != b_score) begin
      return a_score > b_score;
    end
    return a_id < b_id;
  endfunction

  // Rank one accepted word into the model store and, on the last candidate of a
  // set, queue min(k, fill) hits best first and empty the store.
  function automatic void predict_candidate(logic [tks_pkg::ID_W-1:0]    id,
                                            logic [tks_pkg::SCORE_W-1:0] score,
                                            logic                        is_last);
    int   slot;
    int   top_slot;
    int   k_eff;
    int   n_hits;
    hit_t h;
    slot = 0;
    // A duplicate of a kept entry never ranks ahead of it, so it lands after it.
    while (slot < ranked_fill &&
           !ranks_ahead(score, id, ranked_scores[slot], ranked_ids[slot])) begin
      slot++;
    end
    if (slot < tks_pkg::MAX_TOP_K) begin
      // With a full store the bottom entry falls out; otherwise everything moves down.
      top_slot = (ranked_fill < tks_pkg::MAX_TOP_K) ? ranked_fill : tks_pkg::MAX_TOP_K - 1;
      for (int i = top_slot; i > slot; i--) begin
        ranked_ids[i]    = ranked_ids[i-1];
        ranked_scores[i] = ranked_scores[i-1];
      end
      ranked_ids[slot]    = id;
      ranked_scores[slot] = score;
      if (ranked_fill < tks_pkg::MAX_TOP_K) begin
        ranked_fill++;
      end
    end
    if (is_last) begin
      // k above the store depth means the whole store; zero returns nothing.
      k_eff  = (int'(k_setting) > tks_pkg::MAX_TOP_K) ? tks_pkg::MAX_TOP_K :
               int'(k_setting);
      n_hits = (k_eff < ranked_fill) ? k_eff : ranked_fill;
      for (int r = 0; r < n_hits; r++) begin
        h.doc_id  = ranked_ids[r];
        h.score   = ranked_scores[r];
        h.rank    = tks_pkg::RANK_W'(r);
        h.is_last = (r == n_hits - 1);
        pending_hits = {pending_hits, h};
      end
      ranked_fill = 0;
      sets_closed++;
    end
  endfunction

  // Offer one candidate word, with a random gap in front of it when idling is
  // on. Entered and left at a falling edge; valid stays high on return so that
  // back-to-back words never drop it in between.
  task automatic send_candidate(logic [tks_pkg::ID_W-1:0]    id,
                                logic [tks_pkg::SCORE_W-1:0] score,
                                logic                        is_last);
    while (in_gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_doc_id         = id;
    in_score          = score;
    in_last_candidate = is_last;
    do begin
      @(posedge clk);
    end while (in_stall);
    predict_candidate(id, score, is_last);
    candidates_sent++;
    @(negedge clk);
  endtask

  // Change k only while the block is idle: every expected hit has been seen,
  // and any insertion that returns nothing has had time to finish.
  task automatic write_k(logic [tks_pkg::K_W-1:0] value);
    in_valid = 1'b0;
    while (pending_hits.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid    = 1'b1;
    cfg_k_in_use = value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    k_setting = value;
    k_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One random set. Scores mix full-range values, a narrow band that forces
  // ties, the two extremes and whole Q16.16 numbers; some words repeat the
  // previous score or the previous pair exactly.
  task automatic send_random_set(int n_items);
    logic [tks_pkg::ID_W-1:0]    id;
    logic [tks_pkg::SCORE_W-1:0] score;
    logic [tks_pkg::ID_W-1:0]    prev_id;
    logic [tks_pkg::SCORE_W-1:0] prev_score;
    int                          roll;
    int                          pick;
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(99);
      if (i > 0 && roll < 8) begin
        id    = prev_id;
        score = prev_score;
      end else begin
        id = ($urandom_range(99) < 30) ? tks_pkg::ID_W'($urandom_range(15)) :
             tks_pkg::ID_W'($urandom);
        if (i > 0 && roll < 20) begin
          score = prev_score;
        end else begin
          pick = $urandom_range(99);
          if (pick < 50) begin
            score = $urandom;
          end else if (pick < 75) begin
            score = tks_pkg::SCORE_W'($urandom_range(7));
          end else if (pick < 85) begin
            score = $urandom_range(1) ? '1 : '0;
          end else begin
            score = tks_pkg::SCORE_W'($urandom_range(255)) << 16;
          end
        end
      end
      send_candidate(id, score, i == n_items - 1);
      prev_id    = id;
      prev_score = score;
    end
  endtask

  // Reset value of k is ten; the extremes of both fields appear here.
  task automatic test_default_k();
    send_candidate('0, '1, 1'b0);
    send_candidate('1, '0, 1'b0);
    send_candidate(tks_pkg::ID_W'(5), tks_pkg::SCORE_W'(32'h0001_0000), 1'b1);
  endtask

  // Equal scores order by doc id, and an exact duplicate follows its twin.
  task automatic test_ties_and_duplicates();
    send_candidate(tks_pkg::ID_W'(7), tks_pkg::SCORE_W'(32'h0003_8000), 1'b0);
    send_candidate(tks_pkg::ID_W'(3), tks_pkg::SCORE_W'(32'h0003_8000), 1'b0);
    send_candidate(tks_pkg::ID_W'(7), tks_pkg::SCORE_W'(32'h0003_8000), 1'b1);
  endtask

  // With k at zero a set returns nothing but the store is still emptied.
  task automatic test_k_zero();
    write_k(K_ZERO);
    send_candidate(tks_pkg::ID_W'(1), tks_pkg::SCORE_W'(100), 1'b1);
  endtask

  // The k in force at the last candidate decides how many hits come back.
  task automatic test_k_change_mid_set();
    write_k(K_FULL);
    send_candidate(tks_pkg::ID_W'(10), tks_pkg::SCORE_W'(50), 1'b0);
    write_k(K_ONE);
    send_candidate(tks_pkg::ID_W'(11), tks_pkg::SCORE_W'(40), 1'b1);
  endtask

  // Fill the store, drop a candidate below all kept entries, then push the
  // worst entry out with a new best one. k at its top value returns all.
  task automatic test_full_store();
    write_k(K_TOP);
    for (int i = 0; i < tks_pkg::MAX_TOP_K; i++) begin
      send_candidate(tks_pkg::ID_W'(100 + i), tks_pkg::SCORE_W'(1000 + 10 * i), 1'b0);
    end
    send_candidate(tks_pkg::ID_W'(200), tks_pkg::SCORE_W'(5), 1'b0);
    send_candidate(tks_pkg::ID_W'(201), '1, 1'b1);
  endtask

  // Random sets under one k value, mostly short with some that overflow.
  task automatic test_random_phase(logic [tks_pkg::K_W-1:0] k_value, int budget);
    int sent;
    int n_items;
    write_k(k_value);
    sent = 0;
    while (sent < budget) begin
      n_items = ($urandom_range(99) < 25) ? $urandom_range(30, 17) : $urandom_range(12, 1);
      send_random_set(n_items);
      sent += n_items;
    end
  endtask

  // A stretch where neither side idles at all.
  task automatic test_quiet_stretch();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    test_random_phase(K_FULL, 40);
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  // The receiver holds off for a long time while words keep coming, so the
  // block backs up into its input.
  task automatic test_output_backpressure();
    write_k(K_FULL);
    hold_request = 400;
    for (int i = 0; i < 6; i++) begin
      send_random_set($urandom_range(10, 6));
    end
  endtask

  // The receiver: a long hold-off when one is requested, random stalls
  // otherwise. The hold-off is counted down here, one cycle at a time.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = out_gaps_on && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Every accepted hit is compared with the oldest expected one.
  always @(posedge clk) begin
    hit_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        errors++;
        $display("%0t: unexpected hit, expected none, got id %h score %h rank %0d last %b",
                 $time, out_hit_doc_id, out_hit_score, out_hit_rank, out_last_hit);
      end else begin
        want = pending_hits.pop_front();
        hits_checked++;
        if (out_hit_doc_id !== want.doc_id) begin
          errors++;
          $display("%0t: hit_doc_id expected %h got %h", $time, want.doc_id, out_hit_doc_id);
        end
        if (out_hit_score !== want.score) begin
          errors++;
          $display("%0t: hit_score expected %h got %h", $time, want.score, out_hit_score);
        end
        if (out_hit_rank !== want.rank) begin
          errors++;
          $display("%0t: hit_rank expected %0d got %0d", $time, want.rank, out_hit_rank);
        end
        if (out_last_hit !== want.is_last) begin
          errors++;
          $display("%0t: last_hit expected %b got %b", $time, want.is_last, out_last_hit);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d hits still expected", $time, pending_hits.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_doc_id         = '0;
    in_score          = '0;
    in_last_candidate = 1'b0;
    out_stall         = 1'b0;
    cfg_valid         = 1'b0;
    cfg_k_in_use      = '0;
    in_gaps_on        = 1'b1;
    out_gaps_on       = 1'b1;
    hold_request      = 0;
    hold_left         = 0;
    errors            = 0;
    cycle_count       = 0;
    candidates_sent   = 0;
    sets_closed       = 0;
    hits_checked      = 0;
    k_writes          = 0;
    ranked_fill       = 0;
    k_setting         = tks_pkg::K_RESET;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_k();
    test_ties_and_duplicates();
    test_k_zero();
    test_k_change_mid_set();
    test_full_store();

    test_random_phase(K_OVER, 30);
    test_random_phase(K_ZERO, 30);
    test_random_phase(K_ONE, 30);
    test_quiet_stretch();
    test_random_phase(K_TOP, 30);
    test_random_phase(tks_pkg::K_W'($urandom_range(15, 2)), 30);
    test_output_backpressure();
    test_random_phase(tks_pkg::K_RESET, 30);

    in_valid = 1'b0;
    while (pending_hits.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d candidates in %0d sets and checked %0d hits,", candidates_sent,
             sets_closed, hits_checked);
    $display("with %0d k writes from zero to the top value and %0d mismatches.", k_writes,
             errors);
    if (errors == 0 && pending_hits.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
